// ----- src/lhp_pkg.sv -----
// Shared types and constants of the power-of-two bucket histogram.
// Used by the front end, the back end and the top level.
package lhp_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  localparam int unsigned BIDX_W   = 6;
  localparam int unsigned PCT_W    = 17;
  localparam int unsigned SAMPLE_W = 64;
  localparam int unsigned EST_W    = 60;
  localparam int unsigned TOT_W    = 48;
  localparam int unsigned SUM_W    = 63;
  localparam int unsigned IN_DW    = 88;
  localparam int unsigned OUT_DW   = 176;
  localparam logic [PCT_W-1:0] PCT_ONE = 17'h10000;

  typedef struct packed {
    op_e               op;
    logic [BIDX_W-1:0] bucket;
    logic [PCT_W-1:0]  pct;
  } cmd_t;

endpackage

// ----- src/lhp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lhp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lhp_front.sv -----
// Front end: takes input items, finds the bucket of a sample and clamps the percentile.
// Depends on lhp_pkg.
module lhp_front
  import lhp_pkg::*;
#(
  parameter int unsigned BUCKETS = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_op_i,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  input  logic [PCT_W-1:0]    in_pct_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_t                cmd_o
);

  logic              vld_q;
  cmd_t              cmd_q, cmd_d;
  logic [BIDX_W-1:0] bkt;

  // Highest set bit, one-based, capped at BUCKETS-1; non-positive samples land in bucket 0.
  always_comb begin
    bkt = '0;
    if (in_sample_i[SAMPLE_W-1] || in_sample_i == '0) begin
      bkt = '0;
    end else if (in_sample_i >= (SAMPLE_W'(1) << (BUCKETS - 2))) begin
      bkt = BIDX_W'(BUCKETS - 1);
    end else begin
      for (int k = 0; k < BUCKETS - 2; k++) begin
        if (in_sample_i[k]) begin
          bkt = BIDX_W'(k + 1);
        end
      end
    end
  end

  always_comb begin
    cmd_d.op     = op_e'(in_op_i);
    cmd_d.bucket = bkt;
    cmd_d.pct    = (in_pct_i > PCT_ONE) ? PCT_ONE : in_pct_i;
  end

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ----- src/lhp_fifo.sv -----
// Short queue of classified commands between the front and back ends.
// No dependencies.
module lhp_fifo #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign wr_ready_o = cnt_q != CW'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue fill count beyond depth");

endmodule

// ----- src/lhp_back.sv -----
// Back end: updates the bucket store, keeps running totals and answers queries.
// Depends on lhp_pkg and lhp_ram.
module lhp_back
  import lhp_pkg::*;
#(
  parameter int unsigned BUCKETS     = 60,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EST_W-1:0]  out_est_o,
  output logic [TOT_W-1:0]  out_tot_o,
  output logic [SUM_W-1:0]  out_sum_o
);

  localparam int unsigned AW   = $clog2(BUCKETS);
  localparam int unsigned CTW0 = COUNT_WIDTH + $clog2(BUCKETS) + 1;
  localparam int unsigned CTW  = (CTW0 > TOT_W + 1) ? CTW0 : TOT_W + 1;
  localparam int unsigned TW0  = COUNT_WIDTH + BUCKETS;
  localparam int unsigned TW   = (TW0 > 65) ? TW0 : 65;
  localparam int unsigned PW   = 81;
  localparam int unsigned RW   = COUNT_WIDTH + 17;
  localparam int unsigned QW   = 62;
  localparam int unsigned MW   = PCT_W + 32;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_WR, S_MUL_LO, S_MUL_HI, S_WALK_RD, S_WALK_EV, S_INT, S_DONE
  } state_e;

  state_e                 st_q;
  cmd_t                   cmd_q;
  logic [BUCKETS-1:0]     vbit_q;
  logic [CTW-1:0]         tot_q, seen_q, next_cnt;
  logic [TW-1:0]          t_q;
  logic [PW-1:0]          pc_q;
  logic [AW-1:0]          idx_q, steps_q;
  logic [RW-1:0]          r_q, d_q, r2;
  logic [QW-1:0]          q_q, est_q;
  logic                   first_q;
  logic                   mvld_q;
  logic [EST_W-1:0]       mest_q;
  logic [TOT_W-1:0]       mtot_q;
  logic [SUM_W-1:0]       msum_q;

  logic                   we;
  logic [AW-1:0]          raddr, waddr, prev_addr;
  logic [COUNT_WIDTH-1:0] rdata, wdata, cnt_rd;
  logic [63:0]            c64;
  logic [31:0]            mul_half;
  logic [MW-1:0]          prod;
  logic [65:0]            t3;
  logic                   out_free;

  lhp_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BUCKETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Address whose data sits on the RAM output in the current state.
  assign prev_addr   = (st_q == S_ADD_WR) ? cmd_q.bucket[AW-1:0] : idx_q;

  assign cmd_ready_o = (st_q == S_IDLE);
  assign raddr       = (st_q == S_IDLE) ? cmd_i.bucket[AW-1:0] : idx_q;
  assign waddr       = cmd_q.bucket[AW-1:0];
  assign cnt_rd      = vbit_q[prev_addr] ? rdata : '0;
  assign wdata       = cnt_rd + 1'b1;
  assign we          = (st_q == S_ADD_WR) && (cnt_rd != '1);
  assign next_cnt    = seen_q + CTW'(cnt_rd);
  assign c64         = 64'(tot_q);
  assign mul_half    = (st_q == S_MUL_HI) ? c64[63:32] : c64[31:0];
  assign prod        = {32'd0, cmd_q.pct} * {{PCT_W{1'b0}}, mul_half};
  assign r2          = RW'(r_q << 1);
  assign out_free    = !mvld_q || out_ready_i;
  assign t3          = {2'b00, t_q[63:0]} + {1'b0, t_q[63:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      vbit_q  <= '0;
      tot_q   <= '0;
      t_q     <= '0;
      mvld_q  <= 1'b0;
      first_q <= 1'b0;
    end else begin
      if (mvld_q && out_ready_i && st_q != S_DONE) begin
        mvld_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            est_q <= '0;
            case (cmd_i.op)
              OP_ADD:   st_q <= S_ADD_WR;
              OP_CLEAR: begin
                vbit_q <= '0;
                tot_q  <= '0;
                t_q    <= '0;
                st_q   <= S_DONE;
              end
              OP_QUERY: st_q <= S_MUL_LO;
              default:  st_q <= S_DONE;
            endcase
          end
        end
        S_ADD_WR: begin
          if (cnt_rd != '1) begin
            vbit_q[waddr] <= 1'b1;
            tot_q         <= tot_q + 1'b1;
            t_q           <= t_q + (TW'(1) << cmd_q.bucket[AW-1:0]);
          end
          st_q <= S_DONE;
        end
        S_MUL_LO: begin
          pc_q <= PW'(prod);
          st_q <= S_MUL_HI;
        end
        S_MUL_HI: begin
          pc_q   <= pc_q + (PW'(prod) << 32);
          seen_q <= '0;
          idx_q  <= '0;
          st_q   <= S_WALK_RD;
        end
        S_WALK_RD: st_q <= S_WALK_EV;
        S_WALK_EV: begin
          if (cnt_rd != '0 && pc_q <= PW'({next_cnt, 16'h0000})) begin
            r_q     <= RW'(pc_q - PW'({seen_q, 16'h0000}));
            d_q     <= RW'({cnt_rd, 16'h0000});
            q_q     <= '0;
            first_q <= 1'b1;
            steps_q <= (idx_q != '0) ? idx_q - 1'b1 : '0;
            st_q    <= S_INT;
          end else begin
            seen_q <= next_cnt;
            if (idx_q == AW'(BUCKETS - 1)) begin
              st_q <= S_DONE;
            end else begin
              idx_q <= idx_q + 1'b1;
              st_q  <= S_WALK_RD;
            end
          end
        end
        S_INT: begin
          if (first_q) begin
            first_q <= 1'b0;
            if (r_q >= d_q) begin
              q_q <= QW'(1);
              r_q <= r_q - d_q;
            end
          end else if (steps_q != '0) begin
            steps_q <= steps_q - 1'b1;
            if (r2 >= d_q) begin
              r_q <= r2 - d_q;
              q_q <= {q_q[QW-2:0], 1'b1};
            end else begin
              r_q <= r2;
              q_q <= {q_q[QW-2:0], 1'b0};
            end
          end else begin
            est_q <= q_q + QW'(r2 >= d_q)
                   + ((idx_q != '0) ? (QW'(1) << (idx_q - 1'b1)) : '0);
            st_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            mvld_q <= 1'b1;
            mest_q <= est_q[EST_W-1:0];
            mtot_q <= (tot_q > CTW'({TOT_W{1'b1}})) ? '1 : tot_q[TOT_W-1:0];
            msum_q <= ((|t_q[TW-1:64]) || t3[65]) ? '1 : t3[64:2];
            st_q   <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = mvld_q;
  assign out_est_o   = mest_q;
  assign out_tot_o   = mtot_q;
  assign out_sum_o   = msum_q;

  a_totals_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tot_q == '0) == (t_q == '0)) else $error("count and weighted sum disagree");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_INT && !first_q) |-> r_q < d_q) else $error("remainder not reduced");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE && out_free) |=> mvld_q) else $error("result not presented");

endmodule

// ----- src/log2_histogram_percentile.sv -----
// Top level of the power-of-two bucket histogram with percentile query.
// Depends on lhp_pkg, lhp_front, lhp_fifo and lhp_back (which uses lhp_ram).
//
//  Channel  Direction  Carries
//  s_axis   in         tuser: opcode; tdata: sample_value, percentile_q16
//  m_axis   out        tdata: estimate, total_count, sum_estimate
//
// Every item yields exactly one result item.
// In the back end an add takes the command together with the RAM read, then
// writes the bucket, then presents the result; clear and the unused opcode go
// straight to the result. A query takes the command, multiplies in two halves,
// reads and checks each bucket of the walk up to the chosen bucket, then
// interpolates bit-serially and presents the result; an empty histogram walks
// every bucket.
// Reset clears the bucket store at once through per-bucket valid bits.
// The front end and a two-entry queue keep accepting items, until they are full,
// while the back end works or the output stage waits for m_axis_tready.
module log2_histogram_percentile
  import lhp_pkg::*;
#(
  parameter int unsigned BUCKETS     = 60,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [1:0]        s_axis_tuser,  // [1:0] opcode
  input  logic [IN_DW-1:0]  s_axis_tdata,  // [63:0] sample_value, [80:64] percentile_q16
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata   // [59:0] estimate, [107:60] total_count,
                                           // [170:108] sum_estimate
);

  logic  cmd_valid, cmd_ready, q_valid, q_ready;
  cmd_t  cmd, q_cmd;
  logic [EST_W-1:0] est;
  logic [TOT_W-1:0] tot;
  logic [SUM_W-1:0] sum;

  // The front end registers the bucket index of each sample.
  lhp_front #(.BUCKETS(BUCKETS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_sample_i (s_axis_tdata[63:0]),
    .in_pct_i    (s_axis_tdata[80:64]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  lhp_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd_valid),
    .wr_ready_o (cmd_ready),
    .wr_data_i  (cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_cmd)
  );

  // The back end owns the store and the output register.
  lhp_back #(.BUCKETS(BUCKETS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_est_o   (est),
    .out_tot_o   (tot),
    .out_sum_o   (sum)
  );

  assign m_axis_tdata = {5'b00000, sum, tot, est};

endmodule

// ----- bench/tb_log2_histogram_percentile.sv -----
// Self-checking bench for the power-of-two bucket histogram with percentile query.
// Depends on lhp_pkg and the log2_histogram_percentile RTL; the histogram is
// mirrored in the bench and every result item is checked against that mirror.
module tb_log2_histogram_percentile
  import lhp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBKT = 60;
  localparam int CNTW = 32;
  localparam int RANDOM_ITEMS = 1050;
  localparam int HANG_LIMIT = 20000;

  typedef struct packed {
    logic [SUM_W-1:0] sum_est;
    logic [TOT_W-1:0] total;
    logic [EST_W-1:0] est;
  } hist_result_t;

  // Scoreboard: keeps a copy of the bucket store and a queue of predicted results.
  class hist_scoreboard;
    logic [63:0] counts [NBKT];
    hist_result_t pending [$];
    int errors;

    function new();
      foreach (counts[i]) counts[i] = '0;
      errors = 0;
    endfunction

    function int bucket_for(logic [63:0] v);
      int k;
      k = 0;
      if (v == 0 || v[63]) return 0;
      if (v >= (64'd1 << (NBKT - 2))) return NBKT - 1;
      for (int b = 0; b < 64; b++) if (v[b]) k = b + 1;
      return k;
    endfunction

    // Total exact; the 2^i weights are summed in 128 bits and saturated later.
    function logic [127:0] weighted_sum();
      logic [127:0] s;
      s = '0;
      foreach (counts[i]) s += {64'd0, counts[i]} << i;
      return s;
    endfunction

    function logic [63:0] percentile(logic [16:0] p_in);
      logic [63:0] c, seen, x;
      logic [127:0] pc, num, den, tmp;
      logic [16:0] p;
      logic [63:0] q;
      int steps;
      p = (p_in > PCT_ONE) ? PCT_ONE : p_in;
      c = '0;
      foreach (counts[i]) c += counts[i];
      if (c == 0) return '0;
      pc = p * c;
      seen = '0;
      for (int i = 0; i < NBKT; i++) begin
        x = counts[i];
        if (x != 0) begin
          if (pc <= ({64'd0, seen + x} << 16)) begin
            num = pc - ({64'd0, seen} << 16);
            den = {64'd0, x} << 16;
            steps = (i > 0) ? i - 1 : 0;
            // round(num/den * 2^steps), half up
            tmp = ((num << (steps + 1)) + den) / (den << 1);
            q = tmp[63:0];
            if (i > 0) q += 64'd1 << (i - 1);
            return q;
          end
          seen += x;
        end
      end
      return '0;
    endfunction

    function void note_item(op_e op, logic [63:0] sample, logic [16:0] pct);
      hist_result_t r;
      logic [63:0] tot;
      logic [127:0] ws, q;
      int b;
      r.est = '0;
      case (op)
        OP_ADD: begin
          b = bucket_for(sample);
          if (counts[b] < ((64'd1 << CNTW) - 1)) counts[b]++;
        end
        OP_CLEAR: foreach (counts[i]) counts[i] = '0;
        OP_QUERY: r.est = percentile(pct);
        default: ;
      endcase
      tot = '0;
      foreach (counts[i]) tot += counts[i];
      r.total = (tot > {16'd0, {TOT_W{1'b1}}}) ? {TOT_W{1'b1}} : tot[TOT_W-1:0];
      ws = weighted_sum();
      q = (ws >> 2) * 3 + (((ws & 3) * 3) >> 2);
      r.sum_est = (q > {65'd0, {SUM_W{1'b1}}}) ? {SUM_W{1'b1}} : q[SUM_W-1:0];
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(hist_result_t got);
      hist_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.est !== exp_r.est) begin
        $display("%0t: estimate expected %h actual %h", $realtime, exp_r.est, got.est);
        errors++;
      end
      if (got.total !== exp_r.total) begin
        $display("%0t: total_count expected %h actual %h", $realtime, exp_r.total, got.total);
        errors++;
      end
      if (got.sum_est !== exp_r.sum_est) begin
        $display("%0t: sum_estimate expected %h actual %h", $realtime, exp_r.sum_est,
                 got.sum_est);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [1:0] s_axis_tuser = '0;
  logic [IN_DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;

  hist_scoreboard hist_sb = new();
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  log2_histogram_percentile u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Results are checked, and the watchdog is counted, at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) hist_sb.check_result(m_axis_tdata[170:0]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > HANG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off when asked for.
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      phase++;
      if (long_hold) m_axis_tready <= 1'b0;
      else if ((phase / 200) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
    end
  end

  // Offer one item, holding it until accepted; the sender gap decides whether
  // valid drops afterwards.
  task automatic send_item(op_e op, logic [63:0] sample, logic [16:0] pct);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, pct, sample};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    hist_sb.note_item(op, sample, pct);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (hist_sb.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] random_sample();
    logic [63:0] v;
    int sh;
    v = {$urandom, $urandom};
    sh = $urandom_range(0, 63);
    // mostly values spread over all bucket sizes
    case ($urandom_range(0, 5))
      0: return v;
      1: return '0;
      default: return v >> sh;
    endcase
  endfunction

  function automatic logic [16:0] random_pct();
    case ($urandom_range(0, 5))
      0: return PCT_ONE;
      1: return '0;
      2: return 17'h1ffff - 17'($urandom_range(0, 3));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int burst;
    op_e op;
    logic [63:0] edge_vals [9];
    edge_vals = '{64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 64'd0, 64'd1, 64'd2,
                  64'd3, 64'h03ff_ffff_ffff_ffff, 64'h0400_0000_0000_0000,
                  64'h7fff_ffff_ffff_ffff};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: query on an empty histogram, samples at the bottom and top bucket edges,
    // odd opcode, the percentile extremes including values above one, then clear, an add and a query.
    send_item(OP_QUERY, '0, 17'h08000);
    foreach (edge_vals[i]) send_item(OP_ADD, edge_vals[i], '0);
    send_item(OP_NOP, 64'hffff_ffff_ffff_ffff, 17'h1ffff);
    send_item(OP_QUERY, '0, '0);
    send_item(OP_QUERY, '0, 17'd1);
    send_item(OP_QUERY, '0, 17'h08000);
    send_item(OP_QUERY, '0, PCT_ONE);
    send_item(OP_QUERY, '0, 17'h1ffff);
    send_item(OP_CLEAR, 64'hffff_ffff_ffff_ffff, 17'h1ffff);
    send_item(OP_QUERY, '0, PCT_ONE);
    send_item(OP_ADD, 64'h0000_0000_0000_0005, '0);
    send_item(OP_QUERY, '0, 17'h0c000);
    // Sender pauses until every expected result has come.
    drain_results();

    // Long receiver hold-off while the sender keeps offering adds.
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end
      begin
        for (int n = 0; n < 40; n++) send_item(OP_ADD, random_sample(), '0);
      end
    join

    // Random: bursts of mostly adds with rare queries and clears.
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++, n++) begin
        case ($urandom_range(0, 99))
          0, 1: op = OP_CLEAR;
          2: op = OP_NOP;
          3, 4, 5, 6, 7, 8, 9, 10, 11, 12: op = OP_QUERY;
          default: op = OP_ADD;
        endcase
        send_item(op, random_sample(), random_pct());
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
    end

    drain_results();
    repeat (300) @(negedge clk_i);
    if (hist_sb.errors == 0 && hist_sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
